[sv/region_adjacency_builder_defines.svh]
// region_adjacency_builder_defines.svh: assertion macros shared by the queue, front and back rtl files
// expects clk and rst_n to be visible in the including scope
`ifndef REGION_ADJACENCY_BUILDER_DEFINES_SVH
`define REGION_ADJACENCY_BUILDER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define RAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define RAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rab_pkg.sv]
// rab_pkg.sv: shared types, codes and defaults of the region adjacency builder
// no dependencies
package rab_pkg;

  localparam int MAX_REGIONS_DEF = 256;
  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int QUEUE_DEPTH     = 4;

  localparam int LABEL_W  = 16;
  localparam int QUERY_W  = 9;
  localparam int RCOUNT_W = 9;

  localparam logic [RCOUNT_W-1:0] RCOUNT_RESET = 9'd256;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // register index, taken from paddr[2]
  localparam logic REG_REGION_COUNT = 1'b0;

  // request actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // work for the back end
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_MARK  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [LABEL_W-1:0] label;
    logic                      row_end;
    logic [QUERY_W-1:0]        query_first;
    logic [QUERY_W-1:0]        query_second;
  } in_data_t;

  typedef struct packed {
    logic adjacent;
    logic label_valid;
  } out_data_t;

endpackage

[sv/rab_queue.sv]
// rab_queue.sv: small register queue between the front and back ends
// uses region_adjacency_builder_defines.svh for its assertions
`include "region_adjacency_builder_defines.svh"

module rab_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;

  assign full     = (count_r == NW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `RAB_ASSERT(q_no_overflow, !(push && full), "queue pushed while full")
  `RAB_ASSERT(q_no_underflow, !(pop && empty), "queue popped while empty")

endmodule

[sv/rab_front.sv]
// rab_front.sv: accepts requests, tracks row and column labels, forms back-end work
// depends on rab_pkg and region_adjacency_builder_defines.svh
`include "region_adjacency_builder_defines.svh"

module rab_front #(
  parameter int MAX_REGIONS = rab_pkg::MAX_REGIONS_DEF,
  parameter int MAX_COLUMNS = rab_pkg::MAX_COLUMNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rab_pkg::in_data_t             in_data,
  input  logic [rab_pkg::RCOUNT_W-1:0]  region_count,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [5+4*$clog2(MAX_REGIONS)-1:0] q_data
);

  localparam int RW    = $clog2(MAX_REGIONS);
  localparam int LW    = $clog2(MAX_REGIONS + 1);
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int FW    = $clog2(MAX_COLUMNS + 1);
  localparam int MAG_W = rab_pkg::LABEL_W - 1;
  localparam int QX_W  = rab_pkg::QUERY_W + 2;
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLUMNS - 1);

  typedef struct packed {
    rab_pkg::op_t  op;
    logic          label_valid;
    logic          en1;
    logic [RW-1:0] row1;
    logic [RW-1:0] bit1;
    logic          en2;
    logic [RW-1:0] row2;
    logic [RW-1:0] bit2;
  } entry_t;

  logic [LW-1:0] col_mem [MAX_COLUMNS];

  logic              s1_valid_r;
  rab_pkg::in_data_t s1_item_r;
  logic [CW-1:0]     s1_col_r;
  logic              s1_fresh_r;
  logic              s1_fwd_r;
  logic [LW-1:0]     s1_fwd_val_r;
  logic [LW-1:0]     col_q_r;

  logic [CW-1:0] col_pos_r, col_pos_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [LW-1:0] row_last_r, row_last_nxt;

  logic accept, s1_leave, fresh, is_pixel, lab_ok, lab_valid, col_wr, q_ok;
  logic [MAG_W-1:0]            lbl_u;
  logic [LW-1:0]               lab, col_old, col_new, hi1, lo1, hi2, lo2;
  logic [rab_pkg::QUERY_W-1:0] qhi, qlo;
  entry_t                      entry;

  assign in_stall = s1_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign s1_leave = s1_valid_r && !q_full;
  assign q_push   = s1_leave;
  assign q_data   = entry;

  // columns are visited in order from zero, so a fill count marks those seen this frame
  assign fresh = (FW'(col_pos_r) == fill_r);

  always_comb begin
    col_pos_nxt = col_pos_r;
    fill_nxt    = fill_r;
    if (accept) begin
      case (in_data.action)
        rab_pkg::ACT_START: begin
          col_pos_nxt = '0;
          fill_nxt    = '0;
        end
        rab_pkg::ACT_PIXEL: begin
          if (fresh) begin
            fill_nxt = fill_r + 1'b1;
          end
          if (in_data.row_end) begin
            col_pos_nxt = '0;
          end else if (col_pos_r != COL_LAST) begin
            col_pos_nxt = col_pos_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // label check and tracker update
  assign is_pixel  = (s1_item_r.action == rab_pkg::ACT_PIXEL);
  assign lbl_u     = s1_item_r.label[MAG_W-1:0];
  assign lab_ok    = !s1_item_r.label[MAG_W] && (lbl_u != '0)
                     && (lbl_u <= MAG_W'(region_count)) && (lbl_u <= MAG_W'(MAX_REGIONS));
  assign lab_valid = is_pixel && lab_ok;
  assign lab       = LW'(lbl_u);
  assign col_old   = s1_fresh_r ? '0 : (s1_fwd_r ? s1_fwd_val_r : col_q_r);
  assign col_new   = lab_valid ? lab : col_old;
  assign col_wr    = s1_leave && is_pixel;

  assign hi1 = (row_last_r > lab) ? row_last_r : lab;
  assign lo1 = (row_last_r > lab) ? lab : row_last_r;
  assign hi2 = (col_old > lab) ? col_old : lab;
  assign lo2 = (col_old > lab) ? lab : col_old;

  assign q_ok = (s1_item_r.query_first != '0) && (s1_item_r.query_second != '0)
                && (QX_W'(s1_item_r.query_first) <= QX_W'(MAX_REGIONS))
                && (QX_W'(s1_item_r.query_second) <= QX_W'(MAX_REGIONS));
  assign qhi  = (s1_item_r.query_first > s1_item_r.query_second) ?
                s1_item_r.query_first : s1_item_r.query_second;
  assign qlo  = (s1_item_r.query_first > s1_item_r.query_second) ?
                s1_item_r.query_second : s1_item_r.query_first;

  // only the lower triangle is stored: row is the larger label
  always_comb begin
    entry             = '0;
    entry.op          = rab_pkg::OP_NONE;
    entry.label_valid = lab_valid;
    case (s1_item_r.action)
      rab_pkg::ACT_START: begin
        entry.op = rab_pkg::OP_CLEAR;
      end
      rab_pkg::ACT_PIXEL: begin
        entry.op   = rab_pkg::OP_MARK;
        entry.en1  = lab_valid && (row_last_r != '0) && (row_last_r != lab);
        entry.row1 = RW'(hi1 - 1'b1);
        entry.bit1 = RW'(lo1 - 1'b1);
        entry.en2  = lab_valid && (col_old != '0) && (col_old != lab);
        entry.row2 = RW'(hi2 - 1'b1);
        entry.bit2 = RW'(lo2 - 1'b1);
      end
      rab_pkg::ACT_READ: begin
        entry.op   = rab_pkg::OP_READ;
        entry.en1  = q_ok;
        entry.row1 = RW'(qhi - 1'b1);
        entry.bit1 = RW'(qlo - 1'b1);
      end
      default: ;
    endcase
  end

  always_comb begin
    row_last_nxt = row_last_r;
    if (s1_leave) begin
      case (s1_item_r.action)
        rab_pkg::ACT_START: row_last_nxt = '0;
        rab_pkg::ACT_PIXEL: begin
          if (s1_item_r.row_end) begin
            row_last_nxt = '0;
          end else if (lab_valid) begin
            row_last_nxt = lab;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_pos_r  <= '0;
      fill_r     <= '0;
      row_last_r <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_leave) begin
        s1_valid_r <= 1'b0;
      end
      col_pos_r  <= col_pos_nxt;
      fill_r     <= fill_nxt;
      row_last_r <= row_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r    <= in_data;
      s1_col_r     <= col_pos_r;
      s1_fresh_r   <= fresh;
      // same column written by the leaving pixel while it is read here
      s1_fwd_r     <= col_wr && (s1_col_r == col_pos_r);
      s1_fwd_val_r <= col_new;
    end
  end

  always_ff @(posedge clk) begin
    if (col_wr) begin
      col_mem[s1_col_r] <= col_new;
    end
    if (accept) begin
      col_q_r <= col_mem[col_pos_r];
    end
  end

  `RAB_ASSERT(fr_fill_cover, (FW'(col_pos_r) <= fill_r), "column position beyond fill count")
  `RAB_ASSERT(fr_fwd_revisit, (s1_valid_r && s1_fwd_r) |-> !s1_fresh_r,
              "forwarded column value on a first visit")

endmodule

[sv/rab_back.sv]
// rab_back.sv: carries out matrix updates, clears and reads, holds the result register
// depends on rab_pkg and region_adjacency_builder_defines.svh
`include "region_adjacency_builder_defines.svh"

module rab_back #(
  parameter int MAX_REGIONS = rab_pkg::MAX_REGIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  logic [5+4*$clog2(MAX_REGIONS)-1:0] q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rab_pkg::out_data_t                 out_data
);

  localparam int RW = $clog2(MAX_REGIONS);

  typedef struct packed {
    rab_pkg::op_t  op;
    logic          label_valid;
    logic          en1;
    logic [RW-1:0] row1;
    logic [RW-1:0] bit1;
    logic          en2;
    logic [RW-1:0] row2;
    logic [RW-1:0] bit2;
  } entry_t;

  typedef enum logic [1:0] {
    BK_FIRST  = 2'b01,
    BK_SECOND = 2'b10
  } bk_state_t;

  logic [MAX_REGIONS-1:0] adj_mem [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] row_valid_r;
  logic [MAX_REGIONS-1:0] row_q_r;
  logic [MAX_REGIONS-1:0] one_hot;

  bk_state_t state_r, state_nxt;
  entry_t    head;

  logic          out_valid_r;
  logic          res_read_r, res_ok_r, res_rv_r, res_lv_r;
  logic [RW-1:0] res_bit_r;

  logic          out_free, go, two, done, sel1, wr_en, rd_en, clr;
  logic [RW-1:0] wr_row, wr_bit;

  assign head     = q_data;
  assign out_free = !out_valid_r || !out_stall;
  assign go       = !q_empty && out_free;
  // a pixel with both a row pair and a column pair writes the row pair in BK_FIRST and the column pair in BK_SECOND
  assign two      = (head.op == rab_pkg::OP_MARK) && head.en1 && head.en2;
  assign done     = (state_r == BK_SECOND) || !two;
  assign q_pop    = go && done;

  assign sel1   = (state_r == BK_FIRST) && head.en1;
  assign wr_en  = go && (head.op == rab_pkg::OP_MARK) && (sel1 || head.en2);
  assign wr_row = sel1 ? head.row1 : head.row2;
  assign wr_bit = sel1 ? head.bit1 : head.bit2;
  assign rd_en  = go && (head.op == rab_pkg::OP_READ);
  assign clr    = go && (head.op == rab_pkg::OP_CLEAR);

  assign one_hot = {{(MAX_REGIONS-1){1'b0}}, 1'b1} << wr_bit;

  always_comb begin
    state_nxt = state_r;
    if (q_pop) begin
      state_nxt = BK_FIRST;
    end else if (go) begin
      state_nxt = BK_SECOND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FIRST;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr) begin
        row_valid_r <= '0;
      end else if (wr_en) begin
        row_valid_r[wr_row] <= 1'b1;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // a row not yet valid in this frame reads as zero, so its first write lays down the whole row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (row_valid_r[wr_row]) begin
        adj_mem[wr_row][wr_bit] <= 1'b1;
      end else begin
        adj_mem[wr_row] <= one_hot;
      end
    end
    if (rd_en) begin
      row_q_r <= adj_mem[head.row1];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_read_r <= (head.op == rab_pkg::OP_READ);
      res_ok_r   <= head.en1;
      res_rv_r   <= row_valid_r[head.row1];
      res_bit_r  <= head.bit1;
      res_lv_r   <= head.label_valid;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data.adjacent    = res_read_r && res_ok_r && res_rv_r && row_q_r[res_bit_r];
  assign out_data.label_valid = res_lv_r;

  `RAB_ASSERT(bk_second_two, (state_r == BK_SECOND) |-> (!q_empty && two),
              "second write cycle without a two-pair request")
  `RAB_ASSERT_NEXT(bk_split_mark, go && !done, state_r == BK_SECOND,
                   "two-pair request did not move to its second write")

endmodule

[sv/region_adjacency_builder.sv]
// Region adjacency builder. Requests enter on in_valid/in_stall/in_data: start_frame clears the
// adjacency matrix and the label trackers, pixel feeds one label in raster order, read asks
// whether two regions touch. Every request gives exactly one result on out_valid/out_stall/
// out_data, in request order. region_count is written over the APB port when paddr[2] is 0.
// Throughput: the front end takes one request a cycle while in_stall is low; the back end
// has one write port on the matrix, so a pixel that marks both a row pair and a column pair
// writes its pairs one after the other before it leaves the queue. A four-entry queue lets
// the front run ahead of the back.
// out_stall holds the result register; the queue then fills and in_stall rises.
// Reset clears the row valid bits of the matrix, the trackers and the column fill count, and
// sets region_count to 256; no clearing pass is needed.
// depends on rab_pkg, rab_front, rab_queue, rab_back

module region_adjacency_builder #(
  parameter int MAX_REGIONS = rab_pkg::MAX_REGIONS_DEF,
  parameter int MAX_COLUMNS = rab_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rab_pkg::in_data_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rab_pkg::out_data_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rab_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rab_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rab_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int ENTRY_W = 5 + 4 * $clog2(MAX_REGIONS);

  logic [rab_pkg::RCOUNT_W-1:0] region_count_r;
  logic                         q_full, q_empty, q_push, q_pop;
  logic [ENTRY_W-1:0]           q_wdata, q_rdata;
  logic                         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == rab_pkg::REG_REGION_COUNT);
  assign prdata  = reg_sel ? rab_pkg::APB_DATA_W'(region_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_count_r <= rab_pkg::RCOUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      region_count_r <= pwdata[rab_pkg::RCOUNT_W-1:0];
    end
  end

  rab_front #(
    .MAX_REGIONS (MAX_REGIONS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .region_count (region_count_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  rab_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (rab_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  rab_back #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[tb/region_adjacency_builder_tb.sv]
// region_adjacency_builder_tb.sv: self-checking testbench for the region adjacency builder
// predicts the adjacency and label-valid flags of every request and checks them in order
// depends on rab_pkg and region_adjacency_builder
module region_adjacency_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_REGIONS   = rab_pkg::MAX_REGIONS_DEF;
  // narrow column store so one row can run past its last column
  localparam int N_COLUMNS   = 64;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 400;

  class adjacency_checker;
    logic [N_REGIONS-1:0] touch [N_REGIONS];
    logic [8:0]           column_label [N_COLUMNS];
    logic [8:0]           row_label;
    int                   column_pos;
    logic [8:0]           region_count;
    rab_pkg::out_data_t   flags_due [$];
    int errors, requests, frames, valid_pixels, reads, touching;

    function new();
      clear_frame();
      region_count = rab_pkg::RCOUNT_RESET;
    endfunction

    function void clear_frame();
      foreach (touch[i]) touch[i] = '0;
      foreach (column_label[i]) column_label[i] = '0;
      row_label  = '0;
      column_pos = 0;
    endfunction

    function void mark_pair(int p, int q);
      touch[p-1][q-1] = 1'b1;
      touch[q-1][p-1] = 1'b1;
    endfunction

    function void predict_request(rab_pkg::in_data_t req);
      rab_pkg::out_data_t flags;
      int limit;
      int col;
      int lab;
      int qa;
      int qb;
      flags = '0;
      limit = (region_count > N_REGIONS) ? N_REGIONS : region_count;
      requests++;
      case (req.action)
        rab_pkg::ACT_START: begin
          clear_frame();
          frames++;
        end
        rab_pkg::ACT_PIXEL: begin
          col = (column_pos >= N_COLUMNS) ? N_COLUMNS - 1 : column_pos;
          lab = $signed(req.label);
          if (lab >= 1 && lab <= limit) begin
            flags.label_valid = 1'b1;
            valid_pixels++;
            if (row_label != 0 && row_label != lab) mark_pair(row_label, lab);
            row_label = lab[8:0];
            if (column_label[col] != 0 && column_label[col] != lab)
              mark_pair(column_label[col], lab);
            column_label[col] = lab[8:0];
          end
          if (req.row_end) begin
            column_pos = 0;
            row_label  = '0;
          end else if (col < N_COLUMNS - 1) begin
            column_pos = col + 1;
          end else begin
            column_pos = col;
          end
        end
        rab_pkg::ACT_READ: begin
          qa = req.query_first;
          qb = req.query_second;
          reads++;
          if (qa >= 1 && qa <= N_REGIONS && qb >= 1 && qb <= N_REGIONS) begin
            flags.adjacent = touch[qa-1][qb-1];
            if (flags.adjacent) touching++;
          end
        end
        default: ;
      endcase
      flags_due = {flags_due, flags};
    endfunction

    function void check_flags(rab_pkg::out_data_t got);
      rab_pkg::out_data_t want;
      if (flags_due.size() == 0) begin
        $display("%0t: result with nothing expected: adjacent %0b label_valid %0b",
                 $time, got.adjacent, got.label_valid);
        errors++;
        return;
      end
      want = flags_due.pop_front();
      if (got.adjacent !== want.adjacent) begin
        $display("%0t: adjacent expected %0b, got %0b", $time, want.adjacent, got.adjacent);
        errors++;
      end
      if (got.label_valid !== want.label_valid) begin
        $display("%0t: label_valid expected %0b, got %0b",
                 $time, want.label_valid, got.label_valid);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  rab_pkg::in_data_t              in_data;
  logic                           out_valid;
  logic                           out_stall;
  rab_pkg::out_data_t             out_data;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [rab_pkg::APB_ADDR_W-1:0] paddr;
  logic [rab_pkg::APB_DATA_W-1:0] pwdata;
  logic [rab_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  adjacency_checker chk;
  bit  no_idle;
  bit  hold_off_req;
  int  cycle_count;
  int  settings_used;

  region_adjacency_builder #(
    .MAX_REGIONS (N_REGIONS),
    .MAX_COLUMNS (N_COLUMNS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("** region_adjacency_builder: FAILED **");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        stall_left   = LONG_HOLD;
        hold_off_req = 1'b0;
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        chk.check_flags(out_data);
        stall_left = no_idle ? 0 : $urandom_range(0, 14);
      end
    end
  end

  function automatic rab_pkg::in_data_t make_req(logic [1:0] act, int lab, int row_last,
                                                 int qa, int qb);
    rab_pkg::in_data_t r;
    r.action       = act;
    r.label        = lab[15:0];
    r.row_end      = row_last[0];
    r.query_first  = qa[8:0];
    r.query_second = qb[8:0];
    return r;
  endfunction

  task automatic send_request(rab_pkg::in_data_t req);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    chk.predict_request(req);
  endtask

  task automatic set_region_count(int value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.flags_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {rab_pkg::REG_REGION_COUNT, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    chk.region_count = value[8:0];
    settings_used++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic directed_checks();
    send_request(make_req(rab_pkg::ACT_START, 0, 0, 0, 0));
    send_request(make_req(rab_pkg::ACT_PIXEL, 1, 0, 0, 0));
    send_request(make_req(rab_pkg::ACT_PIXEL, 2, 0, 511, 511));
    send_request(make_req(rab_pkg::ACT_PIXEL, 256, 0, 0, 0));
    send_request(make_req(rab_pkg::ACT_PIXEL, 257, 0, 0, 0));
    send_request(make_req(rab_pkg::ACT_PIXEL, 0, 0, 0, 0));
    send_request(make_req(rab_pkg::ACT_PIXEL, -1, 0, 0, 0));
    send_request(make_req(rab_pkg::ACT_PIXEL, -32768, 0, 0, 0));
    send_request(make_req(rab_pkg::ACT_PIXEL, 32767, 1, 0, 0));
    send_request(make_req(rab_pkg::ACT_PIXEL, 3, 0, 0, 0));
    send_request(make_req(rab_pkg::ACT_PIXEL, 2, 0, 0, 0));
    send_request(make_req(2'd3, -1, 1, 511, 511));
    send_request(make_req(rab_pkg::ACT_PIXEL, 256, 1, 0, 0));
    send_request(make_req(rab_pkg::ACT_READ, 0, 0, 1, 2));
    send_request(make_req(rab_pkg::ACT_READ, 0, 0, 2, 1));
    send_request(make_req(rab_pkg::ACT_READ, 0, 0, 256, 2));
    send_request(make_req(rab_pkg::ACT_READ, 0, 0, 1, 3));
    send_request(make_req(rab_pkg::ACT_READ, 0, 0, 1, 256));
    send_request(make_req(rab_pkg::ACT_READ, 0, 0, 0, 1));
    send_request(make_req(rab_pkg::ACT_READ, 0, 0, 257, 1));
    send_request(make_req(rab_pkg::ACT_READ, -1, 1, 511, 511));
    send_request(make_req(rab_pkg::ACT_READ, 0, 0, 256, 256));
    send_request(make_req(rab_pkg::ACT_START, -1, 1, 511, 511));
    send_request(make_req(rab_pkg::ACT_READ, 0, 0, 1, 2));
  endtask

  task automatic random_frame(int count);
    int palette [6];
    int limit;
    int width;
    int col;
    int k;
    int pick;
    int lab;
    bit row_last;
    limit = (chk.region_count > N_REGIONS) ? N_REGIONS : chk.region_count;
    foreach (palette[i])
      palette[i] = (limit > 0) ? $urandom_range(1, limit) : $urandom_range(1, 8);
    width = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
    col = 0;
    send_request(make_req(rab_pkg::ACT_START, $urandom, $urandom, $urandom, $urandom));
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        if ($urandom_range(0, 9) < 7)
          send_request(make_req(rab_pkg::ACT_READ, $urandom, $urandom,
                                palette[$urandom_range(0, 5)], palette[$urandom_range(0, 5)]));
        else
          send_request(make_req(rab_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom));
      end else if (pick < 14) begin
        send_request(make_req(2'd3, $urandom, $urandom, $urandom, $urandom));
      end else if (pick < 15) begin
        send_request(make_req(rab_pkg::ACT_START, $urandom, $urandom, $urandom, $urandom));
        col = 0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          lab = palette[$urandom_range(0, 5)];
        end else if (pick < 88) begin
          lab = $urandom;
        end else begin
          case ($urandom_range(0, 5))
            0:       lab = 0;
            1:       lab = limit;
            2:       lab = limit + 1;
            3:       lab = -1;
            4:       lab = 256;
            default: lab = 257;
          endcase
        end
        row_last = (col == width - 1) || ($urandom_range(0, 49) == 0);
        send_request(make_req(rab_pkg::ACT_PIXEL, lab, int'(row_last), $urandom, $urandom));
        col = row_last ? 0 : col + 1;
      end
    end
    repeat (4)
      send_request(make_req(rab_pkg::ACT_READ, $urandom, $urandom,
                            palette[$urandom_range(0, 5)], palette[$urandom_range(0, 5)]));
  endtask

  task automatic long_row();
    int k;
    no_idle      = 1'b1;
    hold_off_req = 1'b1;
    send_request(make_req(rab_pkg::ACT_START, 0, 0, 0, 0));
    for (k = 0; k < N_COLUMNS + 6; k++)
      send_request(make_req(rab_pkg::ACT_PIXEL, $urandom_range(1, 6),
                            int'(k == N_COLUMNS + 5), $urandom, $urandom));
    no_idle = 1'b0;
    for (k = 0; k < 4; k++)
      send_request(make_req(rab_pkg::ACT_PIXEL, $urandom_range(1, 6), int'(k == 3),
                            $urandom, $urandom));
    repeat (10)
      send_request(make_req(rab_pkg::ACT_READ, $urandom, $urandom,
                            $urandom_range(1, 6), $urandom_range(1, 6)));
  endtask

  initial begin : stimulus
    int rc_plan [8];
    int p;
    int remaining;
    int n;
    chk           = new();
    rc_plan       = '{256, 1, 2, 0, 511, 255, 37, 256};
    no_idle       = 1'b0;
    hold_off_req  = 1'b0;
    settings_used = 1;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_checks();
    for (p = 0; p < 8; p++) begin
      if (p > 0) set_region_count(rc_plan[p]);
      remaining = 32;
      while (remaining > 0) begin
        n       = $urandom_range(12, 30);
        no_idle = ($urandom_range(0, 4) == 0);
        random_frame(n);
        remaining -= n;
      end
      no_idle = 1'b0;
    end
    long_row();

    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.flags_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("checked %0d requests under %0d region_count settings: %0d frames, %0d valid pixels",
             chk.requests, settings_used, chk.frames, chk.valid_pixels);
    $display("%0d adjacency reads, %0d found touching regions; one row ran past the last column",
             chk.reads, chk.touching);
    if (chk.errors == 0 && chk.flags_due.size() == 0)
      $display("** region_adjacency_builder: PASSED **");
    else
      $display("** region_adjacency_builder: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/rab_pkg.sv
sv/rab_queue.sv
sv/rab_front.sv
sv/rab_back.sv
sv/region_adjacency_builder.sv
tb/region_adjacency_builder_tb.sv
